// ===== rtl/inplace_matrix_transpose_core_defines.svh =====
// Assertion macros shared by the transpose core RTL.
// Depends on a clk_i clock and an rst_ni active-low reset in the including scope.
`ifndef INPLACE_MATRIX_TRANSPOSE_CORE_DEFINES_SVH
`define INPLACE_MATRIX_TRANSPOSE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/imt_pkg.sv =====
// Package for the in-place matrix transpose core: widths, codes and the
// controller/datapath command and status structs. No dependencies.
package imt_pkg;

  localparam int MAX_ELEMS_DEF  = 1024;
  localparam int ELEM_WIDTH_DEF = 64;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 64;
  localparam int ST_W   = 2;
  localparam int DIM_W  = 11;
  localparam int NUM_W  = 2 * DIM_W;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD      = 2'd0,
    ACT_TRANSPOSE = 2'd1,
    ACT_READ      = 2'd2
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHAPE = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  // Register word indexes on the configuration port.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic accept;
    logic pend_load;
    logic run_done;
    logic out_move;
    logic clear;
    logic scan_rd;
    logic take_carry;
    logic mod_go;
    logic fetch;
    logic swap;
    logic advance;
  } imt_cmd_t;

  typedef struct packed {
    logic run_req;
    logic clr_end;
    logic moved;
    logic start_end;
    logic dest_is_start;
    logic mod_busy;
  } imt_stat_t;

endpackage

// ===== rtl/imt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module imt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/imt_mod.sv =====
// Iterative remainder unit: (opnd * mult) mod divisor, one quotient bit a cycle.
// Depends on imt_pkg.
module imt_mod #(
  parameter int AW = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic [AW-1:0]           opnd_i,
  input  logic [imt_pkg::DIM_W-1:0] mult_i,
  input  logic [AW-1:0]           divisor_i,
  output logic                    busy_o,
  output logic [AW-1:0]           rem_o
);
  import imt_pkg::*;

  localparam int PW = AW + DIM_W;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] prod_q, prod_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [AW:0]   trial;
  logic [AW:0]   diff;

  // Shift the next product bit into the partial remainder and reduce once.
  assign trial = {rem_q, prod_q[PW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (go_i) begin
      prod_d = PW'(opnd_i) * PW'(mult_i);
      rem_d  = '0;
      cnt_d  = CW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[PW-2:0], 1'b0};
      rem_d  = (trial >= {1'b0, divisor_i}) ? diff[AW-1:0] : trial[AW-1:0];
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/imt_datapath.sv =====
// Datapath of the transpose core: element store, moved map, cycle walk
// registers, remainder unit and result registers. Depends on imt_pkg,
// imt_ram and imt_mod.
module imt_datapath #(
  parameter int MAX_ELEMS  = imt_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = imt_pkg::ELEM_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  imt_pkg::imt_cmd_t         cmd_i,
  output imt_pkg::imt_stat_t        stat_o,
  input  logic [imt_pkg::DIM_W-1:0] rows_i,
  input  logic [imt_pkg::DIM_W-1:0] cols_i,
  input  logic [imt_pkg::ACT_W-1:0] action_i,
  input  logic [imt_pkg::IDX_W-1:0] index_i,
  input  logic [imt_pkg::VAL_W-1:0] value_i,
  output logic [imt_pkg::VAL_W-1:0] read_value_o,
  output logic [imt_pkg::ST_W-1:0]  status_o
);
  import imt_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);

  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      num_m1;
  logic                  shape_bad;
  logic                  idx_bad;
  logic [ST_W-1:0]       st_in;
  logic                  do_load;
  logic                  do_read;
  logic                  run_req;
  logic [IDX_W+AW-1:0]   idx_ext;
  logic [AW-1:0]         idx_addr;

  logic [AW-1:0]         last_q, last_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         start_q, start_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [ELEM_WIDTH-1:0] carry_q, carry_d;
  logic [ST_W-1:0]       pend_st_q;
  logic                  pend_rd_q;
  logic [ST_W-1:0]       out_st_q;
  logic [VAL_W-1:0]      out_val_q;

  logic                  st_wr_en;
  logic [AW-1:0]         st_wr_addr;
  logic [ELEM_WIDTH-1:0] st_wr_data;
  logic                  st_rd_en;
  logic [AW-1:0]         st_rd_addr;
  logic [ELEM_WIDTH-1:0] st_rd_data;
  logic                  mv_wr_en;
  logic [AW-1:0]         mv_wr_addr;
  logic                  mv_wr_data;
  logic                  mv_rd_data;
  logic                  mod_busy;
  logic [AW-1:0]         rem;

  // Shape and index checks on the incoming beat.
  assign num       = NUM_W'(rows_i) * NUM_W'(cols_i);
  assign num_m1    = num - NUM_W'(1);
  assign shape_bad = (num == '0) || (num > NUM_W'(MAX_ELEMS));
  assign idx_bad   = NUM_W'(index_i) >= num;
  assign idx_ext   = (IDX_W + AW)'(index_i);
  assign idx_addr  = idx_ext[AW-1:0];

  always_comb begin
    st_in   = ST_OK;
    do_load = 1'b0;
    do_read = 1'b0;
    run_req = 1'b0;
    unique case (action_i)
      ACT_LOAD, ACT_READ: begin
        if (shape_bad) begin
          st_in = ST_SHAPE;
        end else if (idx_bad) begin
          st_in = ST_INDEX;
        end else begin
          do_load = cmd_i.accept && (action_i == ACT_LOAD);
          do_read = cmd_i.accept && (action_i == ACT_READ);
        end
      end
      ACT_TRANSPOSE: begin
        if (shape_bad) begin
          st_in = ST_SHAPE;
        end else begin
          run_req = (num >= NUM_W'(3));
        end
      end
      default: st_in = ST_OK;
    endcase
  end

  // Walk registers.
  always_comb begin
    last_d  = last_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    pos_d   = pos_q;
    carry_d = carry_q;
    if (cmd_i.accept && run_req) begin
      last_d = num_m1[AW-1:0];
      cnt_d  = '0;
    end
    if (cmd_i.clear) begin
      cnt_d   = cnt_q + AW'(1);
      start_d = AW'(1);
    end
    if (cmd_i.take_carry) begin
      carry_d = st_rd_data;
      pos_d   = start_q;
    end
    if (cmd_i.swap) begin
      carry_d = st_rd_data;
      pos_d   = rem;
    end
    if (cmd_i.advance) begin
      start_d = start_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    cnt_q   <= cnt_d;
    start_q <= start_d;
    pos_q   <= pos_d;
    carry_q <= carry_d;
  end

  // Result stage and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_st_q <= cmd_i.run_done ? ST_OK : st_in;
      pend_rd_q <= cmd_i.run_done ? 1'b0 : do_read;
    end
    if (cmd_i.out_move) begin
      out_st_q  <= pend_st_q;
      out_val_q <= pend_rd_q ? VAL_W'(st_rd_data) : '0;
    end
  end

  // Element store ports.
  assign st_wr_en   = do_load || cmd_i.swap;
  assign st_wr_addr = cmd_i.swap ? rem : idx_addr;
  assign st_wr_data = cmd_i.swap ? carry_q : value_i[ELEM_WIDTH-1:0];
  assign st_rd_en   = do_read || cmd_i.scan_rd || cmd_i.fetch;

  always_comb begin
    priority if (cmd_i.fetch) begin
      st_rd_addr = rem;
    end else if (cmd_i.scan_rd) begin
      st_rd_addr = start_q;
    end else begin
      st_rd_addr = idx_addr;
    end
  end

  // Moved map ports: clear pass writes zero, a swap marks the old position.
  assign mv_wr_en   = cmd_i.clear || cmd_i.swap;
  assign mv_wr_addr = cmd_i.swap ? pos_q : cnt_q;
  assign mv_wr_data = cmd_i.swap;

  imt_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (st_wr_data),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  imt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ELEMS)
  ) u_moved (
    .clk_i     (clk_i),
    .wr_en_i   (mv_wr_en),
    .wr_addr_i (mv_wr_addr),
    .wr_data_i (mv_wr_data),
    .rd_en_i   (cmd_i.scan_rd),
    .rd_addr_i (start_q),
    .rd_data_o (mv_rd_data)
  );

  imt_mod #(
    .AW (AW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_i.mod_go),
    .opnd_i    (pos_q),
    .mult_i    (rows_i),
    .divisor_i (last_q),
    .busy_o    (mod_busy),
    .rem_o     (rem)
  );

  assign stat_o.run_req       = run_req;
  assign stat_o.clr_end       = (cnt_q == last_q - AW'(1));
  assign stat_o.moved         = mv_rd_data;
  assign stat_o.start_end     = (start_q == last_q - AW'(1));
  assign stat_o.dest_is_start = (rem == start_q);
  assign stat_o.mod_busy      = mod_busy;

  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

endmodule

// ===== rtl/imt_ctrl.sv =====
// Controller of the transpose core: handshakes, result stage occupancy and
// the state machine that sequences a transpose run. Depends on imt_pkg.
module imt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  imt_pkg::imt_stat_t  stat_i,
  output imt_pkg::imt_cmd_t   cmd_o
);
  import imt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_SWAP  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;
  logic       oval_q, oval_d;
  logic       out_free;
  logic       in_ready;
  logic       done_q, done_d;

  assign out_free = !oval_q || out_ready_i;
  assign in_ready = (state_q == S_IDLE) && !done_q && (!pend_q || out_free);

  always_comb begin
    state_d        = state_q;
    done_d         = 1'b0;
    cmd_o          = '0;
    cmd_o.out_move = pend_q && out_free;
    cmd_o.accept   = in_valid_i && in_ready;
    if (done_q) begin
      cmd_o.pend_load = 1'b1;
      cmd_o.run_done  = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          if (stat_i.run_req) begin
            state_d = S_CLEAR;
          end else begin
            cmd_o.pend_load = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_end) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.moved) begin
          cmd_o.advance = 1'b1;
          if (stat_i.start_end) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          cmd_o.take_carry = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mod_go = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        if (!stat_i.mod_busy) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        if (stat_i.dest_is_start) begin
          cmd_o.advance = 1'b1;
          if (stat_i.start_end) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_o.pend_load) begin
      pend_d = 1'b1;
    end else if (cmd_o.out_move) begin
      pend_d = 1'b0;
    end
    oval_d = oval_q;
    if (cmd_o.out_move) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
      done_q  <= done_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = oval_q;

endmodule

// ===== rtl/inplace_matrix_transpose_core.sv =====
// Top level of the in-place matrix transpose core: configuration registers,
// controller and datapath. Depends on imt_pkg, imt_ctrl, imt_datapath and
// the assertion macros in inplace_matrix_transpose_core_defines.svh.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  -----------------------------
//   in       sink       in_valid_i / in_ready_o   action_i, index_i, value_i
//   out      source     out_valid_o / out_ready_i read_value_o, status_o
//   cfg      APB slave  psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// Load, read, an unused action code and any rejected action are taken at one
// beat per cycle in while the output is not stalled; each result passes the
// result stage, needed for the registered read of the element store, and the
// output register. A transpose over N = rows * cols elements (N >= 3) first
// clears moved-map entries 0 to N - 2, then walks the permutation cycles: it
// scans each start position and, per moved element, launches the bit-serial
// remainder unit, fetches and swaps; the input is held off for the whole run.
// Reset clears the controller and the configuration registers (rows = cols
// = 1); the element store holds garbage until written. A stalled output beat
// holds in the output register while one more result waits behind it.
`include "inplace_matrix_transpose_core_defines.svh"

module inplace_matrix_transpose_core #(
  parameter int MAX_ELEMS  = imt_pkg::MAX_ELEMS_DEF,
  parameter int ELEM_WIDTH = imt_pkg::ELEM_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [imt_pkg::ACT_W-1:0]  action_i,
  input  logic [imt_pkg::IDX_W-1:0]  index_i,
  input  logic [imt_pkg::VAL_W-1:0]  value_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [imt_pkg::VAL_W-1:0]  read_value_o,
  output logic [imt_pkg::ST_W-1:0]   status_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imt_pkg::APB_AW-1:0] paddr,
  input  logic [imt_pkg::APB_DW-1:0] pwdata,
  output logic [imt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import imt_pkg::*;

  logic [DIM_W-1:0] rows_q, rows_d;
  logic [DIM_W-1:0] cols_q, cols_d;
  logic             cfg_wr;
  imt_cmd_t         cmd;
  imt_stat_t        stat;

  // Configuration registers: word address picks the register, byte offset
  // bits are ignored. Software writes them only while the core is idle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROWS: rows_d = pwdata[DIM_W-1:0];
        REG_COLS: cols_d = pwdata[DIM_W-1:0];
        default:  rows_d = rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(1);
      cols_q <= DIM_W'(1);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(cols_q) : APB_DW'(rows_q);

  // Sequence accepts, result moves and the transpose walk.
  imt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the store, the moved map and the result payload.
  imt_datapath #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rows_i       (rows_q),
    .cols_i       (cols_q),
    .action_i     (action_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

  // A beat that starts a transpose run closes the input until the run ends.
  `IMT_ASSERT_NEXT(a_run_blocks_input, cmd.accept && stat.run_req, !in_ready_o, "input open after run start")
  // Store swaps happen only inside a run, never beside an accepted beat.
  `IMT_ASSERT_NOW(a_swap_no_accept, cmd.swap, !in_ready_o, "input open during swap")
  // The remainder unit is busy right after it is launched.
  `IMT_ASSERT_NEXT(a_mod_launch, cmd.mod_go, stat.mod_busy, "remainder unit did not start")

endmodule

// ===== bench/inplace_matrix_transpose_core_tb.sv =====
// Self-checking bench for inplace_matrix_transpose_core: predicts every status and
// read word of the load, read and in-place transpose actions and checks each result.
// Depends on imt_pkg and the core RTL only.
module inplace_matrix_transpose_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imt_pkg::*;

  localparam int MAX_ELEMS   = MAX_ELEMS_DEF;
  localparam int IDLE_PCT    = 12;      // chance in a hundred of a bubble on either side
  localparam int ITEM_GOAL   = 1150;    // stop sending random beats past this count
  localparam int QUIET_LIMIT = 200000;  // headroom for a quiet 1024-element transpose
  localparam int TAIL_CYCLES = 20;

  // The fourth action code has no package name; the core must answer it with ok.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [VAL_W-1:0] word;
    status_e          code;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ACT_W-1:0]   action_i;
  logic [IDX_W-1:0]   index_i;
  logic [VAL_W-1:0]   value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [VAL_W-1:0]   read_value_o;
  logic [ST_W-1:0]    status_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // Shadow of the core: shape registers, element words, and which entries
  // hold a written word (permuted along with the words on every transpose).
  logic [DIM_W-1:0]   shape_rows;
  logic [DIM_W-1:0]   shape_cols;
  logic [VAL_W-1:0]   mat_words  [MAX_ELEMS];
  bit                 mat_filled [MAX_ELEMS];
  bit                 placed     [MAX_ELEMS];

  result_t            pending_results[$];
  int                 mismatches;
  int                 beats_sent;
  int                 quiet_cycles;
  bit                 steady;     // suppress all bubbles on both sides

  inplace_matrix_transpose_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned shape_elems();
    return int'(shape_rows) * int'(shape_cols);
  endfunction

  // Walk the permutation cycles of the row-major transpose: the word at pos
  // lands at pos * rows mod (n - 1); the first and last entries never move.
  function automatic void permute_store(int unsigned n);
    int unsigned      last;
    int unsigned      pos;
    int unsigned      dest;
    int unsigned      guard;
    logic [VAL_W-1:0] carry_word;
    logic [VAL_W-1:0] tmp_word;
    bit               carry_fill;
    bit               tmp_fill;
    for (int i = 0; i < MAX_ELEMS; i++) placed[i] = 1'b0;
    if (n < 3) return;
    last = n - 1;
    placed[0]    = 1'b1;
    placed[last] = 1'b1;
    for (int unsigned start = 1; start < last; start++) begin
      if (placed[start]) continue;
      pos        = start;
      guard      = 0;
      carry_word = mat_words[start];
      carry_fill = mat_filled[start];
      do begin
        dest             = (pos * shape_rows) % last;
        tmp_word         = mat_words[dest];
        tmp_fill         = mat_filled[dest];
        mat_words[dest]  = carry_word;
        mat_filled[dest] = carry_fill;
        carry_word       = tmp_word;
        carry_fill       = tmp_fill;
        placed[pos]      = 1'b1;
        pos              = dest;
        guard++;
      end while (pos != start && guard < last);
    end
  endfunction

  // Apply one accepted beat to the shadow and queue the result it must cause.
  // The shape check comes first, then the index check; the spare code skips both.
  function automatic void predict_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                       logic [VAL_W-1:0] val);
    result_t     res;
    int unsigned n;
    n        = shape_elems();
    res.word = '0;
    res.code = ST_OK;
    if (act != ACT_SPARE) begin
      if (n == 0 || n > MAX_ELEMS) begin
        res.code = ST_SHAPE;
      end else if (act == ACT_TRANSPOSE) begin
        permute_store(n);
      end else if (idx >= n) begin
        res.code = ST_INDEX;
      end else if (act == ACT_LOAD) begin
        mat_words[idx]  = val;
        mat_filled[idx] = 1'b1;
      end else begin
        res.word = mat_words[idx];
      end
    end
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Return some written entry below n, or -1 when none is; reads never touch
  // an entry that was not loaded.
  function automatic int pick_filled(int n);
    int base;
    if (n <= 0) return -1;
    base = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      if (mat_filled[(base + k) % n]) return (base + k) % n;
    end
    return -1;
  endfunction

  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, output back-pressure and watchdog
  // ---------------------------------------------------------------------------

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: read_value %h status %0d",
               read_value_o, status_o);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value_o !== exp_res.word) begin
          $error("read_value mismatch: expected %h, got %h", exp_res.word, read_value_o);
          mismatches++;
        end
        if (status_o !== exp_res.code) begin
          $error("status mismatch: expected %0d, got %0d", exp_res.code, status_o);
          mismatches++;
        end
      end
    end
  end

  // Drop ready now and then, except during the steady stretch.
  always @(posedge clk_i) begin
    if (steady) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat accepted for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one beat, optionally after a one-cycle bubble, and hold it until taken.
  // Valid stays high on return so back-to-back beats need no extra cycle.
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i   <= act;
    index_i    <= idx;
    value_i    <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(act, idx, val);
    beats_sent++;
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Write one shape register, then read it back; junk goes in the upper bits.
  task automatic write_reg(input logic reg_idx, input logic [DIM_W-1:0] val);
    logic [APB_DW-1:0] junk;
    junk    = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {junk[APB_DW-1:DIM_W], val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_ROWS) shape_rows = val;
    else shape_cols = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[DIM_W-1:0] !== val) begin
      $error("prdata mismatch at %0d: expected %h, got %h", paddr, val, prdata[DIM_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(input int r, input int c);
    wait_idle();
    write_reg(REG_ROWS, DIM_W'(r));
    write_reg(REG_COLS, DIM_W'(c));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Random loads, reads of written entries, out-of-range accesses, spare codes
  // and the odd transpose, all on the current legal shape.
  task automatic run_mixed_beats(input int count);
    int n;
    int sel;
    int idx;
    n = shape_elems();
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      idx = pick_filled(n);
      if (sel < 40 || (sel < 75 && idx < 0)) begin
        send_beat(ACT_LOAD, IDX_W'($urandom_range(n - 1)), random_word());
      end else if (sel < 75) begin
        send_beat(ACT_READ, IDX_W'(idx), random_word());
      end else if (sel < 84 && n < MAX_ELEMS) begin
        send_beat(sel[0] ? ACT_READ : ACT_LOAD, IDX_W'($urandom_range(MAX_ELEMS - 1, n)),
                  random_word());
      end else if (sel < 89) begin
        send_beat(ACT_SPARE, IDX_W'($urandom), random_word());
      end else if (sel < 95) begin
        send_beat(ACT_TRANSPOSE, IDX_W'($urandom), random_word());
      end else if (idx >= 0) begin
        send_beat(ACT_READ, IDX_W'(idx), random_word());
      end else begin
        send_beat(ACT_LOAD, IDX_W'($urandom_range(n - 1)), random_word());
      end
    end
  endtask

  // The well-formed sequence: set a shape, load up to fill entries in shuffled
  // order with reads mixed in, transpose, usually swap the shape the way
  // software would, then a random mix.
  task automatic run_shape_round(input int r, input int c, input int fill, input int mix);
    int n;
    int j;
    int tmp;
    int idx;
    int order[MAX_ELEMS];
    set_shape(r, c);
    n = r * c;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < fill && i < n; i++) begin
      if ($urandom_range(9) != 0) send_beat(ACT_LOAD, IDX_W'(order[i]), random_word());
      idx = pick_filled(n);
      if ($urandom_range(3) == 0 && idx >= 0) send_beat(ACT_READ, IDX_W'(idx), random_word());
    end
    send_beat(ACT_TRANSPOSE, IDX_W'($urandom), random_word());
    if ($urandom_range(9) < 7) set_shape(c, r);
    run_mixed_beats(mix);
  endtask

  // Noise: an illegal shape (zero side or too many elements) and a few beats.
  task automatic run_bad_shape_round();
    case ($urandom_range(2))
      0:       set_shape(0, $urandom_range(2047));
      1:       set_shape($urandom_range(2047), 0);
      default: set_shape($urandom_range(2047, 33), $urandom_range(2047, 32));
    endcase
    repeat ($urandom_range(6, 3)) begin
      send_beat(ACT_W'($urandom_range(3)), IDX_W'($urandom), random_word());
    end
  endtask

  // Extremes of every field, every action, and each corner: shape error,
  // index error, spare code, transposes of one and two elements.
  task automatic test_directed();
    // Reset shape is 1 x 1.
    send_beat(ACT_LOAD, '0, '1);
    send_beat(ACT_READ, '0, '0);
    send_beat(ACT_LOAD, IDX_W'(1), 64'h0123_4567_89ab_cdef);
    send_beat(ACT_READ, '1, '0);
    send_beat(ACT_TRANSPOSE, '0, '0);
    send_beat(ACT_READ, '0, '1);
    set_shape(1, 2);
    send_beat(ACT_LOAD, IDX_W'(1), 64'h8000_0000_0000_0001);
    send_beat(ACT_TRANSPOSE, '1, '1);
    send_beat(ACT_READ, IDX_W'(1), '0);
    // Zero rows: the shape error wins over everything but the spare code.
    set_shape(0, 2047);
    send_beat(ACT_LOAD, '0, '1);
    send_beat(ACT_READ, '0, '0);
    send_beat(ACT_TRANSPOSE, '0, '0);
    send_beat(ACT_SPARE, '1, '1);
    set_shape(2047, 2047);
    send_beat(ACT_READ, IDX_W'(5), '0);
    set_shape(1025, 1);
    send_beat(ACT_TRANSPOSE, '0, '0);
    // Full store: index 1023 is legal.
    set_shape(1024, 1);
    send_beat(ACT_LOAD, '1, 64'h5555_5555_5555_5555);
    send_beat(ACT_LOAD, '0, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(ACT_READ, '1, '0);
    send_beat(ACT_READ, '0, '0);
    set_shape(3, 2);
    for (int i = 0; i < 6; i++) send_beat(ACT_LOAD, IDX_W'(i), {32'(i), ~32'(i)});
    send_beat(ACT_TRANSPOSE, '0, '0);
    send_beat(ACT_READ, IDX_W'(1), '0);
    send_beat(ACT_READ, IDX_W'(4), '0);
  endtask

  // A few big shapes, the full store among them; loads are sparse to keep
  // the item count down while the transpose still walks every cycle.
  task automatic test_large_shapes();
    int big_rows[6] = '{32, 1024, 1, 16, 31, 3};
    int big_cols[6] = '{32, 1, 1024, 64, 33, 341};
    int pick;
    for (int k = 0; k < 3; k++) begin
      pick = (k == 0) ? 0 : $urandom_range(5);
      run_shape_round(big_rows[pick], big_cols[pick], 60, 30);
    end
  endtask

  // Back-to-back stream with no bubbles on either side.
  task automatic test_steady_stream();
    steady = 1'b1;
    run_shape_round($urandom_range(8, 2), $urandom_range(8, 2), 64, 120);
    steady = 1'b0;
  endtask

  // Random shapes until the item goal is reached, mostly small ones.
  task automatic test_random_shapes();
    int r;
    int c;
    while (beats_sent < ITEM_GOAL) begin
      if ($urandom_range(11) == 0) begin
        run_bad_shape_round();
      end else begin
        case ($urandom_range(4))
          0: begin r = 1;                    c = $urandom_range(40, 1); end
          1: begin r = $urandom_range(40, 1); c = 1;                    end
          2: begin r = $urandom_range(12, 1); c = $urandom_range(12, 1); end
          default: begin r = $urandom_range(8, 1); c = $urandom_range(8, 1); end
        endcase
        run_shape_round(r, c, r * c, $urandom_range(24, 8));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_LOAD;
    index_i     <= '0;
    value_i     <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    shape_rows  = DIM_W'(1);
    shape_cols  = DIM_W'(1);
    mismatches  = 0;
    beats_sent  = 0;
    steady      = 1'b0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      mat_words[i]  = '0;
      mat_filled[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_large_shapes();
    test_steady_stream();
    test_random_shapes();

    // Drain: wait for every result, then a short tail to catch strays.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== inplace_matrix_transpose_core.f =====
+incdir+rtl
rtl/imt_pkg.sv
rtl/imt_ram.sv
rtl/imt_mod.sv
rtl/imt_datapath.sv
rtl/imt_ctrl.sv
rtl/inplace_matrix_transpose_core.sv
bench/inplace_matrix_transpose_core_tb.sv
